// ===== design/tqm_pkg.sv =====
// shared types and constants of the timer queue manager
`default_nettype none
package tqm_pkg;

  localparam int unsigned TIMER_SLOTS_DEF = 16;
  localparam int unsigned MAX_RESULTS     = 16;
  localparam logic [63:0] HOUR_MS         = 64'd3600000;

  // request codes
  localparam logic [2:0] REQ_ADD     = 3'd0;
  localparam logic [2:0] REQ_CANCEL  = 3'd1;
  localparam logic [2:0] REQ_REFRESH = 3'd2;
  localparam logic [2:0] REQ_RESET   = 3'd3;
  localparam logic [2:0] REQ_EXPIRE  = 3'd4;
  localparam logic [2:0] REQ_DELAY   = 3'd5;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_ARMED = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_NONE      = 3'd3;
  localparam logic [2:0] ST_EXPIRED   = 3'd4;

  typedef enum logic [1:0] {
    SCAN_EARLY,
    SCAN_CAND,
    SCAN_PICK
  } scan_mode_e;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_STATUS,
    ACT_CANCEL,
    ACT_REFRESH,
    ACT_RESET_WR,
    ACT_RESET_FRONT,
    ACT_ADD,
    ACT_DELAY,
    ACT_CAND_DONE,
    ACT_PICK
  } act_e;

  typedef struct packed {
    logic       scan_start;
    scan_mode_e scan_mode;
    logic       scan_excl;
    act_e       act;
    logic [2:0] status;
    logic       load;
    logic       use_pred;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [2:0] req;
    logic       slot_ok;
    logic       any_armed;
    logic       reset_change;
    logic       scan_done;
    logic       cand_none;
    logic       res_last;
    logic       out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== design/tqm_ram.sv =====
// generic single write port ram with registered read
`default_nettype none
module tqm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem[rd_addr_i];
  end

endmodule
`default_nettype wire

// ===== design/tqm_ctrl.sv =====
// controller state machine of the timer queue manager
`default_nettype none
module tqm_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire tqm_pkg::dp_stat_t stat_i,
  output tqm_pkg::ctrl_cmd_t     cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_MODIFY,
    S_SCAN,
    S_ACT,
    S_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   picking_q, picking_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      picking_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      picking_q <= picking_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    picking_d = picking_q;
    cmd_o     = '{scan_start: 1'b0, scan_mode: tqm_pkg::SCAN_EARLY, scan_excl: 1'b0,
                  act: tqm_pkg::ACT_NONE, status: tqm_pkg::ST_OK, load: 1'b0,
                  use_pred: 1'b0};
    unique case (state_q)
      S_IDLE: begin
        picking_d = 1'b0;
        if (in_valid_i) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat_i.req)
          tqm_pkg::REQ_ADD, tqm_pkg::REQ_DELAY: begin
            cmd_o.scan_start = 1'b1;
            state_d          = S_SCAN;
          end
          tqm_pkg::REQ_CANCEL, tqm_pkg::REQ_REFRESH, tqm_pkg::REQ_RESET: begin
            if (!stat_i.slot_ok) begin
              cmd_o.act    = tqm_pkg::ACT_STATUS;
              cmd_o.status = tqm_pkg::ST_NOT_ARMED;
              state_d      = S_EMIT;
            end else if (stat_i.req == tqm_pkg::REQ_CANCEL) begin
              cmd_o.act = tqm_pkg::ACT_CANCEL;
              state_d   = S_EMIT;
            end else begin
              state_d = S_MODIFY;
            end
          end
          tqm_pkg::REQ_EXPIRE: begin
            if (!stat_i.any_armed) begin
              cmd_o.act    = tqm_pkg::ACT_STATUS;
              cmd_o.status = tqm_pkg::ST_NONE;
              state_d      = S_EMIT;
            end else begin
              cmd_o.scan_start = 1'b1;
              cmd_o.scan_mode  = tqm_pkg::SCAN_CAND;
              state_d          = S_SCAN;
            end
          end
          default: begin
            cmd_o.act    = tqm_pkg::ACT_STATUS;
            cmd_o.status = tqm_pkg::ST_OK;
            state_d      = S_EMIT;
          end
        endcase
      end
      S_MODIFY: begin
        if (stat_i.req == tqm_pkg::REQ_REFRESH) begin
          cmd_o.act = tqm_pkg::ACT_REFRESH;
          state_d   = S_EMIT;
        end else if (stat_i.reset_change) begin
          cmd_o.act        = tqm_pkg::ACT_RESET_WR;
          cmd_o.scan_start = 1'b1;
          cmd_o.scan_excl  = 1'b1;
          state_d          = S_SCAN;
        end else begin
          cmd_o.act    = tqm_pkg::ACT_STATUS;
          cmd_o.status = tqm_pkg::ST_OK;
          state_d      = S_EMIT;
        end
      end
      S_SCAN: begin
        if (stat_i.scan_done) begin
          state_d = S_ACT;
        end
      end
      S_ACT: begin
        state_d = S_EMIT;
        unique case (stat_i.req)
          tqm_pkg::REQ_ADD:   cmd_o.act = tqm_pkg::ACT_ADD;
          tqm_pkg::REQ_RESET: cmd_o.act = tqm_pkg::ACT_RESET_FRONT;
          tqm_pkg::REQ_DELAY: cmd_o.act = tqm_pkg::ACT_DELAY;
          tqm_pkg::REQ_EXPIRE: begin
            if (picking_q) begin
              cmd_o.act = tqm_pkg::ACT_PICK;
            end else begin
              cmd_o.act = tqm_pkg::ACT_CAND_DONE;
              if (!stat_i.cand_none) begin
                cmd_o.scan_start = 1'b1;
                cmd_o.scan_mode  = tqm_pkg::SCAN_PICK;
                picking_d        = 1'b1;
                state_d          = S_SCAN;
              end
            end
          end
          default: cmd_o.act = tqm_pkg::ACT_NONE;
        endcase
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.load     = 1'b1;
          cmd_o.use_pred = (stat_i.req == tqm_pkg::REQ_EXPIRE) && stat_i.any_armed;
          if (picking_q && !stat_i.res_last) begin
            cmd_o.scan_start = 1'b1;
            cmd_o.scan_mode  = tqm_pkg::SCAN_PICK;
            state_d          = S_SCAN;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== design/tqm_dp.sv =====
// datapath of the timer queue manager: slot table, scan engine and result register
`default_nettype none
module tqm_dp #(
  parameter int unsigned TIMER_SLOTS = tqm_pkg::TIMER_SLOTS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_accept_i,
  input  wire logic [2:0]         req_type_i,
  input  wire logic [63:0]        now_ms_i,
  input  wire logic [3:0]         slot_id_i,
  input  wire logic [31:0]        period_ms_i,
  input  wire logic               repeat_req_i,
  input  wire logic               from_now_i,
  input  wire tqm_pkg::ctrl_cmd_t cmd_i,
  output tqm_pkg::dp_stat_t       stat_o,
  input  wire logic               out_ready_i,
  output logic                    out_valid_o,
  output logic [2:0]              status_o,
  output logic [3:0]              result_slot_o,
  output logic [63:0]             delay_ms_o,
  output logic                    new_front_o,
  output logic                    any_armed_o,
  output logic                    last_o
);

  localparam int unsigned IW    = $clog2(TIMER_SLOTS);
  localparam int unsigned CW    = $clog2(tqm_pkg::MAX_RESULTS + 2);
  localparam logic [IW-1:0] LAST_IDX = IW'(TIMER_SLOTS - 1);
  localparam logic [CW-1:0] CNT_SAT  = CW'(tqm_pkg::MAX_RESULTS + 1);
  localparam logic [CW-1:0] CNT_MAX  = CW'(tqm_pkg::MAX_RESULTS);

  // captured request
  logic [2:0]  req_q;
  logic [63:0] now_q;
  logic [3:0]  slot_q;
  logic [31:0] per_q;
  logic        rep_q, fnow_q;

  logic [TIMER_SLOTS-1:0] armed_q, rep_flag_q, cand_q;
  logic        front_q;
  logic [63:0] prev_q;
  logic        jump_q;

  // scan engine
  logic        run_q, v1_q;
  logic [IW-1:0] idx_q, idx1_q;
  tqm_pkg::scan_mode_e mode_q;
  logic        excl_q;
  logic        best_v_q, free_v_q, keep_q;
  logic [63:0] best_d_q;
  logic [IW-1:0] best_idx_q, free_idx_q;
  logic [31:0] best_per_q;
  logic [CW-1:0] cnt_q, k_q, n_lim;
  logic [63:0] nd_q;

  // pending result and output register
  logic [2:0]  res_status_q, o_status_q;
  logic [3:0]  res_slot_q, o_slot_q;
  logic [63:0] res_delay_q, o_delay_q;
  logic        res_nf_q, o_nf_q, res_last_q, o_last_q, o_any_q, out_valid_q;

  // table memory: period above deadline
  logic          wr_en;
  logic [IW-1:0] wr_addr, rd_addr;
  logic [95:0]   wr_data, rd_data;
  logic [31:0]   rd_per;
  logic [63:0]   rd_dl;

  logic [IW-1:0] slot_idx, fs_idx;
  logic [63:0]   fs_d, add_dl, refresh_dl, reset_dl, pick_dl, delay_val;
  logic          consider, due, better, front_hit;

  assign slot_idx   = IW'(slot_q);
  assign rd_per     = rd_data[95:64];
  assign rd_dl      = rd_data[63:0];
  assign rd_addr    = run_q ? idx_q : slot_idx;
  assign add_dl     = now_q + {32'd0, per_q};
  assign refresh_dl = now_q + {32'd0, rd_per};
  assign reset_dl   = (fnow_q ? now_q : (rd_dl - {32'd0, rd_per})) + {32'd0, per_q};
  assign pick_dl    = now_q + {32'd0, best_per_q};
  assign delay_val  = !best_v_q ? '1 : ((now_q > best_d_q) ? 64'd0 : (best_d_q - now_q));
  assign n_lim      = (cnt_q > CNT_MAX) ? CNT_MAX : cnt_q;

  assign consider = (mode_q == tqm_pkg::SCAN_PICK) ? cand_q[idx1_q]
                  : (armed_q[idx1_q] && !(excl_q && (idx1_q == slot_idx)));
  assign due      = armed_q[idx1_q] && (jump_q || (rd_dl <= now_q));
  // ascending scan: an equal deadline never displaces the earlier slot
  assign better   = !best_v_q || (rd_dl < best_d_q);

  assign fs_idx    = (cmd_i.act == tqm_pkg::ACT_ADD) ? free_idx_q : slot_idx;
  assign fs_d      = (cmd_i.act == tqm_pkg::ACT_ADD) ? add_dl : nd_q;
  assign front_hit = !front_q && (!best_v_q || (fs_d < best_d_q)
                     || ((fs_d == best_d_q) && (fs_idx < best_idx_q)));

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = slot_idx;
    wr_data = {rd_per, refresh_dl};
    unique case (cmd_i.act)
      tqm_pkg::ACT_REFRESH: begin
        wr_en = 1'b1;
      end
      tqm_pkg::ACT_RESET_WR: begin
        wr_en   = 1'b1;
        wr_data = {per_q, reset_dl};
      end
      tqm_pkg::ACT_ADD: begin
        wr_en   = free_v_q;
        wr_addr = free_idx_q;
        wr_data = {per_q, add_dl};
      end
      tqm_pkg::ACT_PICK: begin
        wr_en   = rep_flag_q[best_idx_q];
        wr_addr = best_idx_q;
        wr_data = {best_per_q, pick_dl};
      end
      default: wr_en = 1'b0;
    endcase
  end

  tqm_ram #(
    .WIDTH(96),
    .DEPTH(TIMER_SLOTS)
  ) u_table (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q     <= '0;
      rep_flag_q  <= '0;
      cand_q      <= '0;
      front_q     <= 1'b0;
      prev_q      <= '0;
      run_q       <= 1'b0;
      v1_q        <= 1'b0;
      idx_q       <= '0;
      mode_q      <= tqm_pkg::SCAN_EARLY;
      excl_q      <= 1'b0;
      best_v_q    <= 1'b0;
      free_v_q    <= 1'b0;
      keep_q      <= 1'b0;
      cnt_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      v1_q <= run_q;
      if (cmd_i.scan_start) begin
        run_q    <= 1'b1;
        idx_q    <= '0;
        mode_q   <= cmd_i.scan_mode;
        excl_q   <= cmd_i.scan_excl;
        best_v_q <= 1'b0;
        free_v_q <= 1'b0;
        if (cmd_i.scan_mode == tqm_pkg::SCAN_CAND) begin
          cnt_q  <= '0;
          keep_q <= 1'b0;
        end
      end else if (run_q) begin
        idx_q <= idx_q + 1'b1;
        if (idx_q == LAST_IDX) begin
          run_q <= 1'b0;
        end
      end

      if (v1_q) begin
        unique case (mode_q)
          tqm_pkg::SCAN_CAND: begin
            cand_q[idx1_q] <= due;
            if (due && (cnt_q != CNT_SAT)) begin
              cnt_q <= cnt_q + 1'b1;
            end
            // survives the scan unless it fires without repeating
            if (armed_q[idx1_q] && !(due && !rep_flag_q[idx1_q])) begin
              keep_q <= 1'b1;
            end
          end
          default: begin
            if (consider && better) begin
              best_v_q <= 1'b1;
            end
            if ((mode_q == tqm_pkg::SCAN_EARLY) && !armed_q[idx1_q]) begin
              free_v_q <= 1'b1;
            end
          end
        endcase
      end

      unique case (cmd_i.act)
        tqm_pkg::ACT_CANCEL: armed_q[slot_idx] <= 1'b0;
        tqm_pkg::ACT_RESET_FRONT: begin
          if (front_hit) front_q <= 1'b1;
        end
        tqm_pkg::ACT_ADD: begin
          if (free_v_q) begin
            armed_q[free_idx_q]    <= 1'b1;
            rep_flag_q[free_idx_q] <= rep_q;
            if (front_hit) front_q <= 1'b1;
          end
        end
        tqm_pkg::ACT_DELAY: front_q <= 1'b0;
        tqm_pkg::ACT_CAND_DONE: begin
          prev_q <= now_q;
          k_q    <= '0;
        end
        tqm_pkg::ACT_PICK: begin
          if (!rep_flag_q[best_idx_q]) armed_q[best_idx_q] <= 1'b0;
          cand_q[best_idx_q] <= 1'b0;
          k_q                <= k_q + 1'b1;
        end
        default: ;
      endcase

      if (cmd_i.load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept_i) begin
      req_q  <= req_type_i;
      now_q  <= now_ms_i;
      slot_q <= slot_id_i;
      per_q  <= period_ms_i;
      rep_q  <= repeat_req_i;
      fnow_q <= from_now_i;
    end
    jump_q <= (now_q < prev_q) && ((prev_q - now_q) > tqm_pkg::HOUR_MS);
    idx1_q <= idx_q;
    if (v1_q && consider && better && (mode_q != tqm_pkg::SCAN_CAND)) begin
      best_d_q   <= rd_dl;
      best_idx_q <= idx1_q;
      best_per_q <= rd_per;
    end
    if (v1_q && (mode_q == tqm_pkg::SCAN_EARLY) && !armed_q[idx1_q] && !free_v_q) begin
      free_idx_q <= idx1_q;
    end
    if (cmd_i.act == tqm_pkg::ACT_RESET_WR) begin
      nd_q <= reset_dl;
    end

    unique case (cmd_i.act)
      tqm_pkg::ACT_NONE, tqm_pkg::ACT_RESET_WR: ;
      default: begin
        res_status_q <= tqm_pkg::ST_OK;
        res_slot_q   <= '0;
        res_delay_q  <= '0;
        res_nf_q     <= 1'b0;
        res_last_q   <= 1'b1;
        unique case (cmd_i.act)
          tqm_pkg::ACT_STATUS:      res_status_q <= cmd_i.status;
          tqm_pkg::ACT_RESET_FRONT: res_nf_q     <= front_hit;
          tqm_pkg::ACT_ADD: begin
            if (free_v_q) begin
              res_slot_q <= 4'(free_idx_q);
              res_nf_q   <= front_hit;
            end else begin
              res_status_q <= tqm_pkg::ST_FULL;
            end
          end
          tqm_pkg::ACT_DELAY:     res_delay_q  <= delay_val;
          tqm_pkg::ACT_CAND_DONE: res_status_q <= tqm_pkg::ST_NONE;
          tqm_pkg::ACT_PICK: begin
            res_status_q <= tqm_pkg::ST_EXPIRED;
            res_slot_q   <= 4'(best_idx_q);
            res_last_q   <= ((k_q + 1'b1) == n_lim);
          end
          default: ;
        endcase
      end
    endcase

    if (cmd_i.load) begin
      o_status_q <= res_status_q;
      o_slot_q   <= res_slot_q;
      o_delay_q  <= res_delay_q;
      o_nf_q     <= res_nf_q;
      o_last_q   <= res_last_q;
      o_any_q    <= cmd_i.use_pred ? (keep_q || (cnt_q > CNT_MAX)) : (|armed_q);
    end
  end

  assign stat_o.req          = req_q;
  assign stat_o.slot_ok      = (32'(slot_q) < 32'(TIMER_SLOTS)) && armed_q[slot_idx];
  assign stat_o.any_armed    = |armed_q;
  assign stat_o.reset_change = (per_q != rd_per) || fnow_q;
  assign stat_o.scan_done    = v1_q && (idx1_q == LAST_IDX);
  assign stat_o.cand_none    = (cnt_q == '0);
  assign stat_o.res_last     = res_last_q;
  assign stat_o.out_free     = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign status_o      = o_status_q;
  assign result_slot_o = o_slot_q;
  assign delay_ms_o    = o_delay_q;
  assign new_front_o   = o_nf_q;
  assign any_armed_o   = o_any_q;
  assign last_o        = o_last_q;

endmodule
`default_nettype wire

// ===== design/timer_queue_manager.sv =====
// timer queue manager: slot table of deadlines with ordered expiry
//
// Requests enter on the in channel (valid/ready) with the current time; results leave on
// the out channel (valid/ready), one per request, or for an expire scan one per expired
// timer up to MAX_RESULTS, the final one flagged by last. One request is worked on at a
// time; ready is high only while the block is idle.
// Cancel, invalid slot, refresh, an unchanged reset, unknown requests and an expire scan
// on an empty table take no table scan; add and next delay take a full table scan, as
// does a reset that moves the timer. An expire scan takes one candidate scan plus one
// selection scan per expired timer reported. The scans read one slot per cycle from the
// slot table memory.
// Results sit in an output register: the next selection scan runs while a result waits,
// and a stalled receiver simply holds the block until the result is taken.
// Reset disarms all slots and clears the front notice and the last scan time; the table
// memory itself is not cleared.
`default_nettype none
module timer_queue_manager #(
  parameter int unsigned TIMER_SLOTS = tqm_pkg::TIMER_SLOTS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  req_type_i,
  input  wire logic [63:0] now_ms_i,
  input  wire logic [3:0]  slot_id_i,
  input  wire logic [31:0] period_ms_i,
  input  wire logic        repeat_req_i,
  input  wire logic        from_now_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       status_o,
  output logic [3:0]       result_slot_o,
  output logic [63:0]      delay_ms_o,
  output logic             new_front_o,
  output logic             any_armed_o,
  output logic             last_o
);

  tqm_pkg::ctrl_cmd_t cmd;
  tqm_pkg::dp_stat_t  stat;

  tqm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  tqm_dp #(
    .TIMER_SLOTS(TIMER_SLOTS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_accept_i  (in_valid_i && in_ready_o),
    .req_type_i   (req_type_i),
    .now_ms_i     (now_ms_i),
    .slot_id_i    (slot_id_i),
    .period_ms_i  (period_ms_i),
    .repeat_req_i (repeat_req_i),
    .from_now_i   (from_now_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .status_o     (status_o),
    .result_slot_o(result_slot_o),
    .delay_ms_o   (delay_ms_o),
    .new_front_o  (new_front_o),
    .any_armed_o  (any_armed_o),
    .last_o       (last_o)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("accepted a request while busy");

  a_full_means_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == tqm_pkg::ST_FULL) |-> any_armed_o)
    else $error("table full reported with nothing armed");

  a_only_expiry_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> status_o == tqm_pkg::ST_EXPIRED)
    else $error("non-final result that is not an expiry");
`endif

endmodule
`default_nettype wire
